>>> rtl/core/c8_pkg.sv
package c8_pkg;

    localparam int MEM_BYTES_D     = 4096;
    localparam int SCREEN_WIDTH_D  = 64;
    localparam int SCREEN_HEIGHT_D = 32;
    localparam int STACK_DEPTH_D   = 16;

    localparam logic [11:0] PROG_START = 12'h200;
    localparam logic [11:0] FONT_BASE  = 12'h050;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_EXEC = 2'd1;
    localparam logic [1:0] OP_ROW  = 2'd2;

    typedef struct packed {
        logic [7:0] res;
        logic       flag;
        logic       wr_flag;
    } t_alu_out;

    // hex glyphs 0..F, five rows each
    localparam logic [7:0] FONT_ROM [80] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    function automatic logic [7:0] font_byte(input logic [6:0] i);
        return FONT_ROM[i];
    endfunction

endpackage

>>> rtl/core/chip8_instruction_executor.sv
// CHIP-8 core on a stream interface.
// Input item (s_axis): tdata = {rand_byte, keys, data, addr}, tuser = op.
//   op 0 writes a byte to memory, op 1 executes one instruction and ticks
//   the timers, op 2 reads one display row.
// Output item (m_axis): one per input item.
// Items run one at a time through a sequencer around one memory port and
// one ALU. Fx55 and Fx65 step through one register at a time, Dxyn through
// one sprite row at a time and 00E0 through one screen row at a time; a row
// read out of range skips the frame buffer. The next item is accepted at
// the earliest the cycle after the result is taken.
// After reset a clearing pass writes zeros and the font into memory and
// blanks the frame buffer; no item is accepted during it.
// The result sits in an output register; while the receiver stalls no new
// item is accepted.
module chip8_instruction_executor
    import c8_pkg::*;
#(
    parameter int MEM_BYTES     = MEM_BYTES_D,
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_D,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_D,
    parameter int STACK_DEPTH   = STACK_DEPTH_D
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,  // addr, data, keys, rand_byte
    input  logic [1:0]   s_axis_tuser,  // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata   // pc_now, opcode_done, waiting_key,
                                        // sound_active, row_pixels
);
    localparam int AW = $clog2(MEM_BYTES);
    localparam int HW = $clog2(SCREEN_HEIGHT);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int XW = $clog2(SCREEN_WIDTH);

    localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_LDW = 5'd2, S_ROWR = 5'd3,
        S_ROWO = 5'd4, S_F0 = 5'd5, S_F1 = 5'd6, S_F2 = 5'd7, S_EX = 5'd8,
        S_CLS = 5'd9, S_DRD = 5'd10, S_DFB = 5'd11, S_DWR = 5'd12, S_BCD = 5'd13,
        S_ST = 5'd14, S_LD = 5'd15, S_LDR = 5'd16, S_FIN = 5'd17, S_OUT = 5'd18,
        S_DIG = 5'd19;

    logic [4:0] r_st, n_st;
    logic [7:0] mem [MEM_BYTES];
    logic [63:0] fb [SCREEN_HEIGHT];
    logic [11:0] stk [STACK_DEPTH];
    logic [7:0] r_v [16];

    logic [7:0]  r_mrd;
    logic [63:0] r_frd;
    logic [AW:0] r_cnt;
    logic [1:0]  r_op;
    logic [11:0] r_addr;
    logic [7:0]  r_data, r_rnd;
    logic [15:0] r_keys, r_w, r_i;
    logic [11:0] r_pc;
    logic [SW-1:0] r_sp;
    logic [7:0]  r_dt, r_stm;
    logic [4:0]  r_k;
    logic [7:0]  r_bits, r_bval;
    logic [7:0]  r_q10, r_q100;
    logic        r_hit, r_wait;
    logic [63:0] r_row;
    logic [HW-1:0] r_py;
    logic [95:0] r_out;
    logic        r_ov;

    // memory port
    logic          m_we;
    logic [AW-1:0] m_a;
    logic [7:0]    m_wd;
    always_ff @(posedge i_clk) begin
        if (m_we) mem[m_a] <= m_wd;
        r_mrd <= mem[m_a];
    end

    logic          f_we;
    logic [HW-1:0] f_a;
    logic [63:0]   f_wd;
    always_ff @(posedge i_clk) begin
        if (f_we) fb[f_a] <= f_wd;
        r_frd <= fb[f_a];
    end

    logic [3:0] x, y, n;
    logic [7:0] kk, vx, vy;
    assign x = r_w[11:8];
    assign y = r_w[7:4];
    assign n = r_w[3:0];
    assign kk = r_w[7:0];
    assign vx = r_v[x];
    assign vy = r_v[y];

    t_alu_out alu;
    c8_alu u_alu (.i_sub(n), .i_vx(vx), .i_vy(vy), .o_out(alu));

    // decimal digits by reciprocal multiplication
    logic [15:0] q10_p, q100_p;
    assign q10_p  = {8'd0, r_bval} * 16'd205;
    assign q100_p = {8'd0, r_bval} * 16'd41;

    logic [63:0] spr, spr_mask;
    logic [XW-1:0] x0;
    always_comb begin
        x0 = vx[XW-1:0];
        spr = '0;
        for (int c = 0; c < 8; c++) begin
            if (r_bits[7-c]) spr[63 - 32'(XW'(x0 + XW'(c)))] = 1'b1;
        end
        spr_mask = spr;
    end

    logic [AW-1:0] pc_w;
    assign pc_w = r_pc[AW-1:0];

    always_comb begin
        n_st = r_st;
        m_we = 1'b0;
        m_a = pc_w;
        m_wd = '0;
        f_we = 1'b0;
        f_a = r_py;
        f_wd = r_frd ^ spr_mask;
        case (r_st)
            S_CLR: begin
                m_we = 1'b1;
                m_a = r_cnt[AW-1:0];
                m_wd = (r_cnt >= (AW+1)'(FONT_BASE) && r_cnt < (AW+1)'(FONT_BASE + 12'd80))
                    ? font_byte(7'(r_cnt - (AW+1)'(FONT_BASE))) : 8'h00;
                f_we = 1'b1;
                f_a = r_cnt[HW-1:0];
                f_wd = '0;
                if (r_cnt == (AW+1)'(MEM_BYTES - 1)) n_st = S_IDLE;
            end
            S_IDLE: ;
            S_LDW: begin
                m_we = 1'b1;
                m_a = r_addr[AW-1:0];
                m_wd = r_data;
                n_st = S_FIN;
            end
            S_ROWR: begin
                f_a = r_addr[HW-1:0];
                n_st = S_ROWO;
            end
            S_ROWO: n_st = S_FIN;
            S_F0: begin
                m_a = pc_w;
                n_st = S_F1;
            end
            S_F1: begin
                m_a = AW'(pc_w + AW'(1));
                n_st = S_F2;
            end
            S_F2: n_st = S_EX;
            S_EX: begin
                n_st = S_FIN;
                case (r_w[15:12])
                    4'h0: if (r_w == 16'h00E0) n_st = S_CLS;
                    4'hD: if (n != 4'd0) begin
                        m_a = r_i[AW-1:0];
                        n_st = S_DRD;
                    end
                    4'hF: begin
                        if (kk == 8'h33) n_st = S_DIG;
                        if (kk == 8'h55) n_st = S_ST;
                        if (kk == 8'h65) n_st = S_LD;
                    end
                    default: ;
                endcase
            end
            S_CLS: begin
                f_we = 1'b1;
                f_a = r_cnt[HW-1:0];
                f_wd = '0;
                if (r_cnt == (AW+1)'(SCREEN_HEIGHT - 1)) n_st = S_FIN;
            end
            S_DRD: begin
                m_a = AW'(r_i[AW-1:0] + AW'(r_k));
                f_a = r_py;
                n_st = S_DFB;
            end
            S_DFB: n_st = S_DWR;
            S_DWR: begin
                f_we = 1'b1;
                f_a = r_py;
                if (r_k == 5'(n) - 5'd1) n_st = S_FIN;
                else begin
                    m_a = AW'(r_i[AW-1:0] + AW'(r_k) + AW'(1));
                    n_st = S_DRD;
                end
            end
            S_DIG: n_st = S_BCD;
            S_BCD: begin
                m_we = 1'b1;
                m_a = AW'(r_i[AW-1:0] + AW'(r_k));
                m_wd = (r_k == 5'd0) ? r_q100 :
                       (r_k == 5'd1) ? r_q10 - r_q100 * 8'd10 : r_bval - r_q10 * 8'd10;
                if (r_k == 5'd2) n_st = S_FIN;
            end
            S_ST: begin
                m_we = 1'b1;
                m_a = AW'(r_i[AW-1:0] + AW'(r_k));
                m_wd = r_v[r_k[3:0]];
                if (r_k[3:0] == x) n_st = S_FIN;
            end
            S_LD: begin
                m_a = AW'(r_i[AW-1:0] + AW'(r_k));
                n_st = S_LDR;
            end
            S_LDR: begin
                if (r_k[3:0] == x) n_st = S_FIN;
                else n_st = S_LD;
            end
            S_FIN: n_st = S_OUT;
            S_OUT: if (m_axis_tready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
        if (r_st == S_IDLE && s_axis_tvalid) begin
            case (s_axis_tuser)
                OP_LOAD: n_st = S_LDW;
                OP_EXEC: n_st = S_F0;
                OP_ROW:  n_st = (s_axis_tdata[11:0] < 12'(SCREEN_HEIGHT)) ? S_ROWR : S_FIN;
                default: n_st = S_FIN;
            endcase
        end
    end

    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    logic [11:0] pc2;
    logic [3:0] kidx;
    logic       kbit;
    assign pc2 = 12'(AW'(pc_w + AW'(2)));
    assign kbit = r_keys[vx[3:0]];
    always_comb begin
        kidx = 4'd0;
        for (int i = 15; i >= 0; i--) if (r_keys[i]) kidx = 4'(i);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_cnt <= '0;
            r_pc <= 12'(AW'(PROG_START));
            r_sp <= '0;
            r_dt <= '0;
            r_stm <= '0;
            r_i <= '0;
            r_ov <= 1'b0;
            for (int i = 0; i < 16; i++) r_v[i] <= '0;
            for (int i = 0; i < STACK_DEPTH; i++) stk[i] <= '0;
        end else begin
            r_st <= n_st;
            case (r_st)
                S_CLR: r_cnt <= r_cnt + 1'b1;
                S_IDLE: if (s_axis_tvalid) begin
                    r_op <= s_axis_tuser;
                    r_addr <= s_axis_tdata[11:0];
                    r_data <= s_axis_tdata[19:12];
                    r_keys <= s_axis_tdata[35:20];
                    r_rnd <= s_axis_tdata[43:36];
                    r_row <= '0;
                    r_wait <= 1'b0;
                    r_w <= '0;
                    r_k <= '0;
                    r_hit <= 1'b0;
                    r_cnt <= '0;
                end
                S_ROWO: r_row <= r_frd;
                S_F2: r_pc <= pc2;
                S_EX: begin
                    r_w[7:0] <= r_w[7:0];
                    r_py <= HW'(vy[HW-1:0]);
                    r_bval <= vx;
                    case (r_w[15:12])
                        4'h0: if (r_w == 16'h00EE) begin
                            r_sp <= SW'(r_sp - SW'(1));
                            r_pc <= 12'(AW'(stk[SW'(r_sp - SW'(1))][AW-1:0]));
                        end
                        4'h1: r_pc <= 12'(AW'(r_w[11:0]));
                        4'h2: begin
                            stk[r_sp] <= r_pc;
                            r_sp <= SW'(r_sp + SW'(1));
                            r_pc <= 12'(AW'(r_w[11:0]));
                        end
                        4'h3: if (vx == kk) r_pc <= pc2;
                        4'h4: if (vx != kk) r_pc <= pc2;
                        4'h5: if (n == 4'd0 && vx == vy) r_pc <= pc2;
                        4'h6: r_v[x] <= kk;
                        4'h7: r_v[x] <= vx + kk;
                        4'h8: begin
                            // flag wins when VF is the destination
                            if (!(alu.wr_flag && x == 4'hF)) r_v[x] <= alu.res;
                            if (alu.wr_flag) r_v[15] <= {7'd0, alu.flag};
                        end
                        4'h9: if (n == 4'd0 && vx != vy) r_pc <= pc2;
                        4'hA: r_i <= {4'd0, r_w[11:0]};
                        4'hB: r_pc <= 12'(AW'(r_w[11:0] + {4'd0, r_v[0]}));
                        4'hC: r_v[x] <= r_rnd & kk;
                        4'hD: if (n == 4'd0) r_v[15] <= 8'd0;
                        4'hE: begin
                            if (kk == 8'h9E && kbit) r_pc <= pc2;
                            if (kk == 8'hA1 && !kbit) r_pc <= pc2;
                        end
                        default: case (kk)
                            8'h07: r_v[x] <= r_dt;
                            8'h0A: if (r_keys == 16'd0) begin
                                r_pc <= 12'(AW'(pc_w - AW'(2)));
                                r_wait <= 1'b1;
                            end else r_v[x] <= {4'd0, kidx};
                            8'h15: r_dt <= vx;
                            8'h18: r_stm <= vx;
                            8'h1E: r_i <= r_i + {8'd0, vx};
                            8'h29: r_i <= 16'(FONT_BASE) + {10'd0, vx[3:0], 2'b00}
                                          + {12'd0, vx[3:0]};
                            default: ;
                        endcase
                    endcase
                end
                S_CLS: r_cnt <= r_cnt + 1'b1;
                S_DFB: r_bits <= r_mrd;
                S_DWR: begin
                    if ((r_frd & spr_mask) != '0) r_hit <= 1'b1;
                    r_py <= (32'(r_py) == SCREEN_HEIGHT - 1) ? '0 : HW'(r_py + HW'(1));
                    r_k <= r_k + 5'd1;
                    if (r_k == 5'(n) - 5'd1)
                        r_v[15] <= {7'd0, r_hit | ((r_frd & spr_mask) != '0)};
                end
                S_DIG: begin
                    r_q10 <= {3'd0, q10_p[15:11]};
                    r_q100 <= {4'd0, q100_p[15:12]};
                end
                S_BCD, S_ST: r_k <= r_k + 5'd1;
                S_LDR: begin
                    r_v[r_k[3:0]] <= r_mrd;
                    r_k <= r_k + 5'd1;
                end
                S_FIN: begin
                    if (r_op == OP_EXEC) begin
                        if (r_dt != 8'd0) r_dt <= r_dt - 8'd1;
                        if (r_stm != 8'd0) r_stm <= r_stm - 8'd1;
                    end
                    r_ov <= 1'b1;
                    r_out <= {2'b00, r_row,
                              (r_op == OP_EXEC) ? (r_stm > 8'd1) : (r_stm != 8'd0),
                              r_wait, r_w, r_pc};
                end
                S_OUT: if (m_axis_tready) r_ov <= 1'b0;
                default: ;
            endcase
            if (r_st == S_F1) r_w[15:8] <= r_mrd;
            if (r_st == S_F2) r_w <= {r_w[15:8], r_mrd};
        end
    end
endmodule

>>> rtl/core/c8_alu.sv
module c8_alu
    import c8_pkg::*;
(
    input  logic [3:0] i_sub,
    input  logic [7:0] i_vx,
    input  logic [7:0] i_vy,
    output t_alu_out   o_out
);
    logic [8:0] sum;
    always_comb begin
        o_out = '{res: i_vx, flag: 1'b0, wr_flag: 1'b0};
        sum = '0;
        case (i_sub)
            4'h0: o_out.res = i_vy;
            4'h1: o_out.res = i_vx | i_vy;
            4'h2: o_out.res = i_vx & i_vy;
            4'h3: o_out.res = i_vx ^ i_vy;
            4'h4: begin
                sum = {1'b0, i_vx} + {1'b0, i_vy};
                o_out = '{res: sum[7:0], flag: sum[8], wr_flag: 1'b1};
            end
            4'h5: o_out = '{res: i_vx - i_vy, flag: i_vx > i_vy, wr_flag: 1'b1};
            4'h6: o_out = '{res: {1'b0, i_vx[7:1]}, flag: i_vx[0], wr_flag: 1'b1};
            4'h7: o_out = '{res: i_vy - i_vx, flag: i_vy > i_vx, wr_flag: 1'b1};
            4'hE: o_out = '{res: {i_vx[6:0], 1'b0}, flag: i_vx[7], wr_flag: 1'b1};
            default: o_out = '{res: i_vx, flag: 1'b0, wr_flag: 1'b0};
        endcase
    end
endmodule

>>> bench/chip8_instruction_executor_tb.sv
`timescale 1ns / 1ps

module chip8_instruction_executor_tb;
    import c8_pkg::*;

    localparam int MEMSZ    = 4096;
    localparam int ROWS     = 32;
    localparam int NSTACK   = 16;
    localparam int LIMIT    = 600000;
    localparam int HOLD_CYC = 3000;

    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [3:0]  pad;
        logic [7:0]  rnd;
        logic [15:0] keys;
        logic [7:0]  data;
        logic [11:0] addr;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  pad;
        logic [63:0] row;
        logic        sound;
        logic        waiting;
        logic [15:0] opword;
        logic [11:0] pc;
    } resp_t;

    localparam logic [7:0] GLYPHS [80] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;  // addr, data, keys, rand_byte
    logic [1:0]  s_axis_tuser;  // op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;  // pc_now, opcode_done, waiting_key, sound_active, row_pixels

    chip8_instruction_executor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // CPU state mirror
    logic [7:0]  mem   [MEMSZ];
    logic [63:0] fb    [ROWS];
    logic [7:0]  v     [16];
    logic [15:0] ireg;
    logic [11:0] pc;
    logic [11:0] stk   [NSTACK];
    logic [3:0]  sp;
    logic [7:0]  dtimer;
    logic [7:0]  stimer;

    cmd_t       cmd_q   [$];
    logic [1:0] op_q    [$];
    resp_t      resp_q  [$];

    int  errors = 0;
    int  cycles = 0;
    int  results_seen = 0;
    bit  in_taken = 0;
    bit  hold = 0;
    int  send_gap = 0;
    int  recv_stall = 0;
    bit  calm = 0;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
    endtask

    task automatic cpu_reset();
        for (int a = 0; a < MEMSZ; a++) mem[a] = 8'h00;
        for (int a = 0; a < 80; a++) mem[32'(FONT_BASE) + a] = GLYPHS[a];
        for (int r = 0; r < ROWS; r++) fb[r] = '0;
        for (int r = 0; r < 16; r++) v[r] = '0;
        for (int r = 0; r < NSTACK; r++) stk[r] = '0;
        ireg = '0; pc = PROG_START; sp = '0; dtimer = '0; stimer = '0;
    endtask

    task automatic cond_skip(input bit c);
        if (c) pc = pc + 12'd2;
    endtask

    task automatic run_word(input logic [15:0] w, input logic [15:0] keys,
                            input logic [7:0] rnd, output bit waiting);
        logic [3:0] x, y, n;
        logic [7:0] kk, vx, vy, res, bits;
        logic       flag, hit, found;
        logic [5:0] x0, px;
        logic [4:0] y0, py;
        x = w[11:8]; y = w[7:4]; n = w[3:0]; kk = w[7:0];
        vx = v[x]; vy = v[y];
        waiting = 0;
        case (w[15:12])
            4'h0: begin
                if (w == 16'h00E0) begin
                    for (int r = 0; r < ROWS; r++) fb[r] = '0;
                end else if (w == 16'h00EE) begin
                    sp = sp - 4'd1;
                    pc = stk[sp];
                end
            end
            4'h1: pc = w[11:0];
            4'h2: begin
                stk[sp] = pc;
                sp = sp + 4'd1;
                pc = w[11:0];
            end
            4'h3: cond_skip(vx == kk);
            4'h4: cond_skip(vx != kk);
            4'h5: if (n == 0) cond_skip(vx == vy);
            4'h6: v[x] = kk;
            4'h7: v[x] = vx + kk;
            4'h8: begin
                case (n)
                    4'h0: v[x] = vy;
                    4'h1: v[x] = vx | vy;
                    4'h2: v[x] = vx & vy;
                    4'h3: v[x] = vx ^ vy;
                    4'h4: begin {flag, res} = {1'b0, vx} + {1'b0, vy}; v[x] = res; v[15] = {7'd0, flag}; end
                    4'h5: begin v[x] = vx - vy; v[15] = {7'd0, vx > vy}; end
                    4'h6: begin v[x] = vx >> 1; v[15] = {7'd0, vx[0]}; end
                    4'h7: begin v[x] = vy - vx; v[15] = {7'd0, vy > vx}; end
                    4'hE: begin v[x] = vx << 1; v[15] = {7'd0, vx[7]}; end
                    default: ;
                endcase
            end
            4'h9: if (n == 0) cond_skip(vx != vy);
            4'hA: ireg = {4'd0, w[11:0]};
            4'hB: pc = w[11:0] + {4'd0, v[0]};
            4'hC: v[x] = rnd & kk;
            4'hD: begin
                x0 = vx[5:0]; y0 = vy[4:0]; hit = 0;
                for (int r = 0; r < n; r++) begin
                    bits = mem[12'(ireg + 16'(r))];
                    py = y0 + 5'(r);
                    for (int c = 0; c < 8; c++) begin
                        if (bits[7 - c]) begin
                            px = x0 + 6'(c);
                            if (fb[py][63 - px]) hit = 1;
                            fb[py][63 - px] = ~fb[py][63 - px];
                        end
                    end
                end
                v[15] = {7'd0, hit};
            end
            4'hE: begin
                if (kk == 8'h9E) cond_skip(keys[vx[3:0]]);
                else if (kk == 8'hA1) cond_skip(!keys[vx[3:0]]);
            end
            default: begin
                case (kk)
                    8'h07: v[x] = dtimer;
                    8'h0A: begin
                        found = 0;
                        for (int k = 0; k < 16; k++)
                            if (!found && keys[k]) begin v[x] = 8'(k); found = 1; end
                        if (!found) begin pc = pc - 12'd2; waiting = 1; end
                    end
                    8'h15: dtimer = vx;
                    8'h18: stimer = vx;
                    8'h1E: ireg = ireg + {8'd0, vx};
                    8'h29: ireg = 16'(FONT_BASE) + 16'd5 * {12'd0, vx[3:0]};
                    8'h33: begin
                        mem[ireg[11:0]]         = vx / 8'd100;
                        mem[12'(ireg + 16'd1)]  = (vx / 8'd10) % 8'd10;
                        mem[12'(ireg + 16'd2)]  = vx % 8'd10;
                    end
                    8'h55: for (int r = 0; r <= x; r++) mem[12'(ireg + 16'(r))] = v[r];
                    8'h65: for (int r = 0; r <= x; r++) v[r] = mem[12'(ireg + 16'(r))];
                    default: ;
                endcase
            end
        endcase
    endtask

    task automatic cpu_item(input logic [1:0] op, input cmd_t c, output resp_t r);
        logic [15:0] w;
        bit          waiting;
        r = '0;
        case (op)
            OP_LOAD: mem[c.addr] = c.data;
            OP_EXEC: begin
                w = {mem[pc], mem[pc + 12'd1]};
                pc = pc + 12'd2;
                run_word(w, c.keys, c.rnd, waiting);
                r.opword = w;
                r.waiting = waiting;
                if (dtimer != 0) dtimer--;
                if (stimer != 0) stimer--;
            end
            default: if (op == OP_ROW && c.addr < ROWS) r.row = fb[c.addr[4:0]];
        endcase
        r.pc = pc;
        r.sound = (stimer != 0);
    endtask

    task automatic send(input logic [1:0] op, input logic [11:0] addr, input logic [7:0] data,
                        input logic [15:0] keys, input logic [7:0] rnd);
        cmd_t  c;
        resp_t r;
        c = '{pad: '0, rnd: rnd, keys: keys, data: data, addr: addr};
        cpu_item(op, c, r);
        cmd_q.push_back(c);
        op_q.push_back(op);
        resp_q.push_back(r);
    endtask

    // place one instruction at the current pc and execute it
    task automatic step_instr(input logic [15:0] w, input logic [15:0] keys, input logic [7:0] rnd);
        send(OP_LOAD, pc, w[15:8], 16'($urandom), 8'($urandom));
        send(OP_LOAD, pc + 12'd1, w[7:0], 16'($urandom), 8'($urandom));
        send(OP_EXEC, 12'($urandom), 8'($urandom), keys, rnd);
    endtask

    function automatic logic [15:0] pick_word();
        logic [15:0] w;
        logic [7:0]  fsub [9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65};
        logic [3:0]  asub [9] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE};
        w = 16'($urandom);
        case (w[15:12])
            4'h0: case ($urandom_range(0, 3))
                0: w = 16'h00E0;
                1, 2: w = 16'h00EE;
                default: ;
            endcase
            4'h5, 4'h9: if ($urandom_range(0, 4) != 0) w[3:0] = 4'h0;
            4'h8: if ($urandom_range(0, 7) != 0) w[3:0] = asub[$urandom_range(0, 8)];
            4'hE: case ($urandom_range(0, 4))
                0, 1: w[7:0] = 8'h9E;
                2, 3: w[7:0] = 8'hA1;
                default: ;
            endcase
            4'hF: if ($urandom_range(0, 7) != 0) w[7:0] = fsub[$urandom_range(0, 8)];
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [15:0] pick_keys();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'h1 << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    // driver
    always @(posedge i_clk) in_taken <= s_axis_tvalid && s_axis_tready;

    always @(negedge i_clk) begin
        logic  nvalid;
        cmd_t  c;
        nvalid = s_axis_tvalid;
        if (!i_rst_n) begin
            nvalid = 0;
        end else if (in_taken || !s_axis_tvalid) begin
            nvalid = 0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (op_q.size() > 0) begin
                c = cmd_q.pop_front();
                s_axis_tuser <= op_q.pop_front();
                s_axis_tdata <= c;
                nvalid = 1;
                if ($urandom_range(0, 99) < 2) calm = ~calm;
                send_gap = calm ? 0 : $urandom_range(0, 12);
            end
        end
        s_axis_tvalid <= nvalid;
    end

    // receiver
    always @(negedge i_clk) begin
        if (recv_stall > 0) recv_stall--;
        m_axis_tready <= i_rst_n && !hold && recv_stall == 0;
    end

    always @(posedge i_clk) begin
        resp_t got, want;
        cycles++;
        if (cycles > LIMIT) begin
            $display("FAIL chip8_instruction_executor");
            $finish;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            results_seen++;
            recv_stall = calm ? 0 : $urandom_range(0, 12);
            if (resp_q.size() == 0) begin
                report("unexpected item", got, '0);
            end else begin
                want = resp_q.pop_front();
                if (got.pc !== want.pc) report("pc_now", got.pc, want.pc);
                if (got.opword !== want.opword) report("opcode_done", got.opword, want.opword);
                if (got.waiting !== want.waiting) report("waiting_key", got.waiting, want.waiting);
                if (got.sound !== want.sound) report("sound_active", got.sound, want.sound);
                if (got.row !== want.row) report("row_pixels", got.row, want.row);
            end
        end
    end

    // long receiver hold so the core backs up
    initial begin
        wait (results_seen >= 300);
        @(negedge i_clk);
        hold = 1;
        repeat (HOLD_CYC) @(posedge i_clk);
        hold = 0;
    end

    initial begin
        logic [15:0] w;
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_LOAD;
        m_axis_tready = 0;
        i_rst_n       = 0;
        cpu_reset();

        // directed: ALU flags, VF as destination, sprite wrap, key wait, address wrap
        step_instr(16'h60FF, 16'h0, 8'h00);
        step_instr(16'h6101, 16'h0, 8'h00);
        step_instr(16'h8014, 16'h0, 8'h00);
        step_instr(16'h6F05, 16'h0, 8'h00);
        step_instr(16'h6E03, 16'h0, 8'h00);
        step_instr(16'h8FE5, 16'h0, 8'h00);
        step_instr(16'h6281, 16'h0, 8'h00);
        step_instr(16'h820E, 16'h0, 8'h00);
        step_instr(16'h6AF3, 16'h0, 8'h00);
        step_instr(16'hFA29, 16'h0, 8'h00);
        step_instr(16'h6A3F, 16'h0, 8'h00);
        step_instr(16'h6B1F, 16'h0, 8'h00);
        step_instr(16'hDAB5, 16'h0, 8'h00);
        step_instr(16'hDAB5, 16'h0, 8'h00);
        send(OP_ROW, 12'd31, 8'h00, 16'h0, 8'h00);
        send(OP_ROW, 12'd3, 8'hFF, 16'hFFFF, 8'hFF);
        send(OP_ROW, 12'hFFF, 8'h00, 16'h0, 8'h00);
        send(OP_SPARE, 12'd0, 8'h00, 16'h0, 8'h00);
        step_instr(16'hF50A, 16'h0000, 8'h00);
        step_instr(16'hF50A, 16'h8000, 8'h00);
        step_instr(16'hE59E, 16'h8000, 8'h00);
        step_instr(16'hC3F0, 16'h0, 8'hAB);
        step_instr(16'h1FFE, 16'h0, 8'h00);
        step_instr(16'hF318, 16'h0, 8'h00);
        step_instr(16'hAFFF, 16'h0, 8'h00);
        step_instr(16'hF333, 16'h0, 8'h00);

        // random programs with a little noise
        while (op_q.size() < 1200) begin
            case ($urandom_range(0, 19))
                0: send(OP_LOAD, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
                1: send(OP_SPARE, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
                2, 3: send(OP_ROW, ($urandom_range(0, 7) == 0) ? 12'($urandom) :
                           12'($urandom_range(0, 31)), 8'($urandom), 16'($urandom), 8'($urandom));
                4: begin
                    step_instr({4'hF, 4'($urandom), 8'h29}, 16'h0, 8'($urandom));
                    step_instr({4'hD, 8'($urandom), 4'($urandom_range(1, 5))},
                               16'h0, 8'($urandom));
                end
                default: begin
                    w = pick_word();
                    step_instr(w, pick_keys(), 8'($urandom));
                end
            endcase
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        wait (op_q.size() == 0 && resp_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS chip8_instruction_executor");
        end else begin
            $display("FAIL chip8_instruction_executor");
        end
        $finish;
    end

endmodule
